/* design/kvad_pkg.sv */
// Shared types, codes and constant tables of the key/value cache attention block.
// Used by kvad_ctrl, kvad_dp and the top level kv_cache_attention_decode.
// Depends on nothing.
package kvad_pkg;

    // Fixed field geometry of the stream beats.
    localparam int PW        = 7;    // position field width
    localparam int EW        = 16;   // vector element width, Q8.8
    localparam int NLANE     = 4;    // vector lanes carried on the ports
    localparam int LW        = 2;    // lane index width
    localparam int IN_DATA_W = 136;  // slot, position, 4 first, 4 second elements
    localparam int OUT_DATA_W = 64;  // four result elements
    localparam int ST_W      = 2;

    // Internal arithmetic widths.
    localparam int SC_W   = 35;      // scaled score
    localparam int ACC_W  = 40;      // weighted value sum
    localparam int WS_W   = 23;      // weight sum
    localparam int W_W    = 17;      // one weight
    localparam int DIV_W  = 41;      // divider remainder
    localparam int Q_W    = 17;      // quotient bits
    localparam int DIV_STEPS = 17;

    // Opcodes and status codes.
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_UNWR  = 2'd2;

    // log2(e) in Q16.16.
    localparam logic [16:0] LOG2E = 17'd94548;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic          capture;
        logic          clr;
        logic          store_we;
        logic          set_range;
        logic          set_unwr;
        logic          p1_issue;
        logic          p2_issue;
        logic [PW-1:0] idx;
        logic          div_start;
        logic [LW-1:0] lane;
        logic          out_load;
    } kvad_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic          is_query;
        logic          range_err;
        logic          pos_zero;
        logic [PW-1:0] position;
        logic          busy;
        logic          unwritten;
        logic          div_busy;
        logic          out_free;
    } kvad_st_t;

    // Rounded 2^16 / sqrt(dim).
    function automatic logic [16:0] inv_sqrt(input int dim);
        logic [16:0] v;
        begin
            case (dim)
                1:       v = 17'd65536;
                2:       v = 17'd46341;
                3:       v = 17'd37837;
                default: v = 17'd32768;
            endcase
            return v;
        end
    endfunction

    // 2^16 * 2^(k/16), rounded.
    function automatic logic [16:0] exp2_base(input logic [3:0] k);
        logic [16:0] v;
        begin
            case (k)
                4'd0:    v = 17'd65536;
                4'd1:    v = 17'd68438;
                4'd2:    v = 17'd71468;
                4'd3:    v = 17'd74632;
                4'd4:    v = 17'd77936;
                4'd5:    v = 17'd81386;
                4'd6:    v = 17'd84990;
                4'd7:    v = 17'd88752;
                4'd8:    v = 17'd92682;
                4'd9:    v = 17'd96785;
                4'd10:   v = 17'd101070;
                4'd11:   v = 17'd105545;
                4'd12:   v = 17'd110218;
                4'd13:   v = 17'd115098;
                4'd14:   v = 17'd120194;
                default: v = 17'd125515;
            endcase
            return v;
        end
    endfunction

    // Step from table entry k to entry k+1.
    function automatic logic [12:0] exp2_diff(input logic [3:0] k);
        logic [12:0] v;
        begin
            case (k)
                4'd0:    v = 13'd2902;
                4'd1:    v = 13'd3030;
                4'd2:    v = 13'd3164;
                4'd3:    v = 13'd3304;
                4'd4:    v = 13'd3450;
                4'd5:    v = 13'd3604;
                4'd6:    v = 13'd3762;
                4'd7:    v = 13'd3930;
                4'd8:    v = 13'd4103;
                4'd9:    v = 13'd4285;
                4'd10:   v = 13'd4475;
                4'd11:   v = 13'd4673;
                4'd12:   v = 13'd4880;
                4'd13:   v = 13'd5096;
                4'd14:   v = 13'd5321;
                default: v = 13'd5557;
            endcase
            return v;
        end
    endfunction

endpackage

/* design/kvad_ctrl.sv */
// Sequencing controller of the attention block: walks store, scoring pass,
// weighting pass, per-lane division and result hand-off.
// Depends on kvad_pkg.
module kvad_ctrl
    import kvad_pkg::*;
#(
    parameter int DIM = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  kvad_st_t   st,
    output kvad_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_P1    = 4'd2;
    localparam logic [3:0] S_P1W   = 4'd3;
    localparam logic [3:0] S_P2    = 4'd4;
    localparam logic [3:0] S_P2W   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DIVW  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic [LW-1:0] lane_reg, lane_next;
    logic          last_idx;

    assign last_idx = (idx_reg == st.position - PW'(1));

    // Next-state and command decode.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        lane_next  = lane_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.idx    = idx_reg;
        cmd.lane   = lane_reg;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.clr  = 1'b1;
                idx_next = '0;
                if (st.range_err)
                begin
                    cmd.set_range = 1'b1;
                    state_next    = S_OUT;
                end
                else if (!st.is_query)
                begin
                    cmd.store_we = 1'b1;
                    state_next   = S_OUT;
                end
                else if (st.pos_zero)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_P1;
                end
            end
            S_P1:
            begin
                cmd.p1_issue = 1'b1;
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = S_P1W;
                end
                else
                begin
                    idx_next = idx_reg + PW'(1);
                end
            end
            S_P1W:
            begin
                if (!st.busy)
                begin
                    if (st.unwritten)
                    begin
                        cmd.set_unwr = 1'b1;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        state_next = S_P2;
                    end
                end
            end
            S_P2:
            begin
                cmd.p2_issue = 1'b1;
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = S_P2W;
                end
                else
                begin
                    idx_next = idx_reg + PW'(1);
                end
            end
            S_P2W:
            begin
                if (!st.busy)
                begin
                    lane_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW:
            begin
                if (!st.div_busy)
                begin
                    if (lane_reg == LW'(DIM - 1))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        lane_next  = lane_reg + LW'(1);
                        state_next = S_DIV;
                    end
                end
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            lane_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            lane_reg  <= lane_next;
        end
    end

endmodule

/* design/kvad_dp.sv */
// Datapath of the attention block: key/value/score memories, scoring and
// weighting pipelines, accumulators, serial divider and output register.
// Depends on kvad_pkg; driven by kvad_ctrl.
module kvad_dp
    import kvad_pkg::*;
#(
    parameter int MAX_LEN = 64,
    parameter int DIM     = 4,
    parameter int SLOTS   = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic [ST_W-1:0]        m_tuser,
    input  kvad_cmd_t              cmd,
    output kvad_st_t               st
);

    localparam int DEPTH = SLOTS * MAX_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int VW    = DIM * EW;
    localparam logic [16:0] ISQ = inv_sqrt(DIM);

    // Captured input beat.
    logic                 op_reg;
    logic                 slot_reg;
    logic [PW-1:0]        pos_reg;
    logic signed [EW-1:0] fv_reg [DIM];
    logic signed [EW-1:0] sv_reg [DIM];

    // Storage.
    logic [VW-1:0]        key_mem   [DEPTH];
    logic [VW-1:0]        value_mem [DEPTH];
    logic [SC_W-1:0]      score_mem [MAX_LEN];
    logic [DEPTH-1:0]     written_reg;

    logic [AW-1:0]        st_addr, rd_addr;
    logic [VW-1:0]        key_wr, value_wr;

    // Scoring pass.
    logic [3:0]                p1_v_reg;
    logic [PW-1:0]             p1_idx_reg [4];
    logic [VW-1:0]             key_rd_reg;
    logic                      p1_wr_reg;
    logic signed [31:0]        kq_reg [DIM];
    logic signed [33:0]        dot_reg, dot_next;
    logic signed [51:0]        sprod;
    logic signed [SC_W-1:0]    score_reg;
    logic signed [SC_W-1:0]    best_reg;
    logic                      unwr_reg;

    // Weighting pass.
    logic [4:0]                p2_v_reg;
    logic signed [SC_W-1:0]    score_rd_reg;
    logic [VW-1:0]             val1_reg, val2_reg, val3_reg, val4_reg;
    logic signed [35:0]        dfull;
    logic signed [22:0]        dcl;
    logic signed [40:0]        lp_next, lp_reg;
    logic signed [24:0]        yv;
    logic signed [8:0]         nexp, nneg;
    logic                      zero3_reg;
    logic [4:0]                sh3_reg;
    logic [16:0]               base3_reg;
    logic [24:0]               ip3_reg;
    logic [16:0]               mval;
    logic [W_W-1:0]            w4_reg, w5_reg;
    logic signed [33:0]        wv5_reg [DIM];
    logic signed [ACC_W-1:0]   acc_reg [DIM];
    logic [WS_W-1:0]           wsum_reg;

    // Divider.
    logic                      div_busy_reg;
    logic [4:0]                div_cnt_reg;
    logic [DIV_W-1:0]          rem_reg, dvs_reg;
    logic [Q_W-1:0]            q_reg, q_next;
    logic                      neg_reg;
    logic [LW-1:0]             dlane_reg;
    logic                      ge;
    logic signed [ACC_W-1:0]   acc_sel;
    logic [ACC_W-1:0]          acc_mag;
    logic [EW-1:0]             sat_q;

    // Result and output register.
    logic [EW-1:0]             res_reg [NLANE];
    logic [ST_W-1:0]           status_reg;
    logic                      m_valid_reg;
    logic [OUT_DATA_W-1:0]     m_data_reg;
    logic [ST_W-1:0]           m_user_reg;

    // Input capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= s_tuser;
            slot_reg <= s_tdata[0];
            pos_reg  <= s_tdata[PW:1];
            for (int c = 0; c < DIM; c++)
            begin
                fv_reg[c] <= s_tdata[8 + EW * c +: EW];
                sv_reg[c] <= s_tdata[8 + EW * (NLANE + c) +: EW];
            end
        end
    end

    // Range checks and addresses.
    always_comb
    begin
        st_addr = AW'(slot_reg) * AW'(MAX_LEN) + AW'(pos_reg);
        rd_addr = AW'(slot_reg) * AW'(MAX_LEN) + AW'(cmd.idx);
        for (int c = 0; c < DIM; c++)
        begin
            key_wr[c * EW +: EW]   = fv_reg[c];
            value_wr[c * EW +: EW] = sv_reg[c];
        end
    end

    assign st.is_query  = (op_reg == OP_QUERY);
    assign st.range_err = (int'(slot_reg) >= SLOTS) ||
                          ((op_reg == OP_QUERY) ? (int'(pos_reg) > MAX_LEN)
                                                : (int'(pos_reg) >= MAX_LEN));
    assign st.pos_zero  = (pos_reg == '0);
    assign st.position  = pos_reg;
    assign st.busy      = (|p1_v_reg) || (|p2_v_reg);
    assign st.unwritten = unwr_reg;
    assign st.div_busy  = div_busy_reg;
    assign st.out_free  = !m_valid_reg || m_tready;

    // Key memory: store write, scoring-pass read.
    always_ff @(posedge clk)
    begin
        if (cmd.store_we)
        begin
            key_mem[st_addr] <= key_wr;
        end
        if (cmd.p1_issue)
        begin
            key_rd_reg <= key_mem[rd_addr];
        end
    end

    // Value memory: store write, weighting-pass read.
    always_ff @(posedge clk)
    begin
        if (cmd.store_we)
        begin
            value_mem[st_addr] <= value_wr;
        end
        if (cmd.p2_issue)
        begin
            val1_reg <= value_mem[rd_addr];
        end
    end

    // Score memory: written at the end of the scoring pass.
    always_ff @(posedge clk)
    begin
        if (p1_v_reg[3])
        begin
            score_mem[SW'(p1_idx_reg[3])] <= score_reg;
        end
        if (cmd.p2_issue)
        begin
            score_rd_reg <= score_mem[SW'(cmd.idx)];
        end
    end

    // Written map.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (cmd.store_we)
        begin
            written_reg[st_addr] <= 1'b1;
        end
    end

    // Scoring pass arithmetic.
    always_comb
    begin
        dot_next = '0;
        for (int c = 0; c < DIM; c++)
        begin
            dot_next = dot_next + 34'(kq_reg[c]);
        end
        sprod = $signed(dot_reg) * $signed({1'b0, ISQ});
    end

    always_ff @(posedge clk)
    begin
        p1_wr_reg     <= written_reg[rd_addr];
        p1_idx_reg[0] <= cmd.idx;
        for (int s = 1; s < 4; s++)
        begin
            p1_idx_reg[s] <= p1_idx_reg[s - 1];
        end
        for (int c = 0; c < DIM; c++)
        begin
            kq_reg[c] <= $signed(fv_reg[c]) * $signed(key_rd_reg[c * EW +: EW]);
        end
        dot_reg   <= dot_next;
        score_reg <= sprod[50:16];
    end

    // Weighting pass arithmetic.
    always_comb
    begin
        dfull = 36'(score_rd_reg) - 36'(best_reg);
        if (dfull < -36'sd4194304)
        begin
            dcl = 23'h400000;
        end
        else
        begin
            dcl = dfull[22:0];
        end
        lp_next = $signed(dcl) * $signed({1'b0, LOG2E});
        yv      = lp_reg[40:16];
        nexp    = yv[24:16];
        nneg    = -nexp;
        mval    = base3_reg + 17'(ip3_reg[24:12]);
    end

    always_ff @(posedge clk)
    begin
        val2_reg  <= val1_reg;
        lp_reg    <= lp_next;
        val3_reg  <= val2_reg;
        zero3_reg <= (nexp < -9'sd31);
        sh3_reg   <= nneg[4:0];
        base3_reg <= exp2_base(yv[15:12]);
        ip3_reg   <= 25'(exp2_diff(yv[15:12])) * 25'(yv[11:0]);
        val4_reg  <= val3_reg;
        w4_reg    <= zero3_reg ? '0 : (mval >> sh3_reg);
        w5_reg    <= w4_reg;
        for (int c = 0; c < DIM; c++)
        begin
            wv5_reg[c] <= $signed({1'b0, w4_reg}) * $signed(val4_reg[c * EW +: EW]);
        end
    end

    // Pass valids, running maximum, accumulators and the unwritten flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= '0;
            p2_v_reg <= '0;
            unwr_reg <= 1'b0;
            best_reg <= '0;
            wsum_reg <= '0;
            for (int c = 0; c < DIM; c++)
            begin
                acc_reg[c] <= '0;
            end
        end
        else
        begin
            p1_v_reg <= {p1_v_reg[2:0], cmd.p1_issue};
            p2_v_reg <= {p2_v_reg[3:0], cmd.p2_issue};
            if (cmd.clr)
            begin
                unwr_reg <= 1'b0;
                wsum_reg <= '0;
                for (int c = 0; c < DIM; c++)
                begin
                    acc_reg[c] <= '0;
                end
            end
            else
            begin
                if (p1_v_reg[0] && !p1_wr_reg)
                begin
                    unwr_reg <= 1'b1;
                end
                if (p1_v_reg[3] && ((p1_idx_reg[3] == '0) || (score_reg > best_reg)))
                begin
                    best_reg <= score_reg;
                end
                if (p2_v_reg[4])
                begin
                    wsum_reg <= wsum_reg + WS_W'(w5_reg);
                    for (int c = 0; c < DIM; c++)
                    begin
                        acc_reg[c] <= acc_reg[c] + ACC_W'(wv5_reg[c]);
                    end
                end
            end
        end
    end

    // Divider operand select and one restoring step.
    always_comb
    begin
        acc_sel = acc_reg[cmd.lane];
        acc_mag = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
        ge      = (rem_reg >= dvs_reg);
        q_next  = {q_reg[Q_W-2:0], ge};
        if (!neg_reg)
        begin
            sat_q = (q_next > Q_W'(32767)) ? 16'h7fff : q_next[EW-1:0];
        end
        else
        begin
            sat_q = (q_next > Q_W'(32768)) ? 16'h8000 : EW'(-q_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg   <= DIV_W'(acc_mag) + DIV_W'(wsum_reg >> 1);
            dvs_reg   <= DIV_W'(wsum_reg) << 16;
            q_reg     <= '0;
            neg_reg   <= acc_sel[ACC_W-1];
            dlane_reg <= cmd.lane;
        end
        else if (div_busy_reg)
        begin
            rem_reg <= ge ? (rem_reg - dvs_reg) : rem_reg;
            dvs_reg <= dvs_reg >> 1;
            q_reg   <= q_next;
        end
    end

    // Divider control and result lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            status_reg   <= ST_OK;
            for (int c = 0; c < NLANE; c++)
            begin
                res_reg[c] <= '0;
            end
        end
        else
        begin
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    div_busy_reg       <= 1'b0;
                    res_reg[dlane_reg] <= sat_q;
                end
            end
            if (cmd.clr)
            begin
                status_reg <= cmd.set_range ? ST_RANGE : ST_OK;
                for (int c = 0; c < NLANE; c++)
                begin
                    res_reg[c] <= '0;
                end
            end
            else if (cmd.set_unwr)
            begin
                status_reg <= ST_UNWR;
            end
        end
    end

    // Output register: holds a finished result until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_user_reg <= status_reg;
            for (int c = 0; c < NLANE; c++)
            begin
                m_data_reg[c * EW +: EW] <= res_reg[c];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // A result is never loaded over one that the sink has not taken.
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("result loaded over a pending beat");

    // The two passes never overlap in the pipeline.
    a_pass_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (|p1_v_reg) |-> !(|p2_v_reg))
        else $error("scoring and weighting passes overlap");

    // The divider is started only when idle.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy_reg)
        else $error("divider restarted while busy");

    // The weighting pass runs only over fully written entries.
    a_p2_written: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.p2_issue |-> !unwr_reg)
        else $error("weighting pass over an unwritten entry");

endmodule

/* design/kv_cache_attention_decode.sv */
// Top level of the single-head attention block over a key/value cache.
// Depends on kvad_pkg, kvad_ctrl and kvad_dp.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser is the
//   opcode: a store writes a key and a value vector at an entry of a slot, a
//   query attends over the first "position" entries of a slot.
//   Every input beat produces exactly one output beat on m_tvalid/m_tready,
//   with the attention result in m_tdata and the status code in m_tuser.
//   One item is processed at a time; s_tready is high only while idle.
//   A store or a rejected item goes from the check to the output register,
//   and a query that meets an unwritten entry stops after the scoring pass.
//   A query over P entries walks a scoring pass and a weighting pass at one
//   entry per cycle (one memory read port each), with a pipeline drain after
//   each pass, and then per output lane a 17-step serial divider. The next
//   input beat can be taken the cycle after the result is loaded.
//   Reset clears the written-entry map, so every entry reads as unwritten.
//   The key and value memories are not cleared.
//   A finished result waits in the output register while the sink stalls;
//   the block then holds the next result until the register frees.
module kv_cache_attention_decode
    import kvad_pkg::*;
#(
    parameter int MAX_LEN = 64,
    parameter int DIM     = 4,
    parameter int SLOTS   = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // slot, position, first_vec_0..3, second_vec_0..3 (lowest bit up)
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // opcode
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_0, result_1, result_2, result_3 (lowest bit up)
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status
    output logic [ST_W-1:0]       m_tuser
);

    kvad_cmd_t cmd;
    kvad_st_t  st;

    // Sequencing controller.
    kvad_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Storage and arithmetic.
    kvad_dp #(
        .MAX_LEN (MAX_LEN),
        .DIM     (DIM),
        .SLOTS   (SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .st       (st)
    );

endmodule
